@@ rtl/core/nggp_pkg.sv @@
package nggp_pkg;

  // Default count of minute fraction digits kept in a coordinate field
  localparam int unsigned FRAC_DIGITS_DEF = 5;

  // Digit accumulator ceiling, 2^34-1
  localparam logic [34:0] ACC_MAX = 35'd17179869183;

  // Output bus width: 261 bits of payload padded to whole bytes
  localparam int unsigned TDATA_W = 264;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // Field positions within the sentence
  localparam logic [3:0] FLD_TIME    = 4'd1;
  localparam logic [3:0] FLD_LAT     = 4'd2;
  localparam logic [3:0] FLD_NS      = 4'd3;
  localparam logic [3:0] FLD_LON     = 4'd4;
  localparam logic [3:0] FLD_EW      = 4'd5;
  localparam logic [3:0] FLD_FIX     = 4'd6;
  localparam logic [3:0] FLD_SATS    = 4'd7;
  localparam logic [3:0] FLD_HDOP    = 4'd8;
  localparam logic [3:0] FLD_ALT     = 4'd9;
  localparam logic [3:0] FLD_GEOID   = 4'd11;
  localparam logic [3:0] FLD_AGE     = 4'd13;
  localparam logic [3:0] FLD_STATION = 4'd14;
  localparam logic [3:0] FLD_LIMIT   = 4'd15;

  // Coordinate held as quotient and remainder of the degree split
  typedef struct packed {
    logic [27:0] deg;
    logic [29:0] rem;
    logic [2:0]  frac;
    logic        neg;
    logic        hemi;
  } coord_t;

  // Finished sentence handed from the parser to the converter
  typedef struct packed {
    logic        status;
    logic [29:0] utc;
    coord_t      lat;
    coord_t      lon;
    logic [15:0] fix;
    logic [15:0] sats;
    logic [27:0] hdop;
    logic [27:0] alt;
    logic [27:0] geoid;
    logic [27:0] age;
    logic [15:0] station;
  } snap_t;

  function automatic logic [63:0] pow10(input logic [2:0] n);
    logic [63:0] r;
    case (n)
      3'd0:    r = 64'd1;
      3'd1:    r = 64'd10;
      3'd2:    r = 64'd100;
      3'd3:    r = 64'd1000;
      3'd4:    r = 64'd10000;
      3'd5:    r = 64'd100000;
      3'd6:    r = 64'd1000000;
      3'd7:    r = 64'd10000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

  // Largest accumulator value that survives scaling by 10^n
  function automatic logic [34:0] acc_lim(input logic [2:0] n);
    logic [34:0] r;
    case (n)
      3'd0:    r = 35'd17179869183;
      3'd1:    r = 35'd1717986918;
      3'd2:    r = 35'd171798691;
      3'd3:    r = 35'd17179869;
      3'd4:    r = 35'd1717986;
      3'd5:    r = 35'd171798;
      3'd6:    r = 35'd17179;
      3'd7:    r = 35'd1717;
      default: r = 35'd17179869183;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/nmea_gga_sentence_parser_unit.sv @@
// GGA sentence parser.
// Slave stream: one ASCII character per request on s_axis_tdata_i, with
// s_axis_tlast_i high on the final character of a sentence. A leading '$'
// is skipped, fields split at ',', text after '*' only feeds the tag search.
// Master stream: one request per sentence, issued for its final character;
// tuser carries the status flag, tdata the converted fields.
// Throughput: one character per cycle while s_axis_tready_o is high; the
// per-character work is a compare and a multiply-by-ten accumulate between
// the input register and the parser state.
// Path of a sentence from acceptance of its final character to
// m_axis_tvalid_o: input register, parser commit, degree split multiply,
// divide-by-60 reciprocal multiply into the output register.
// Reset clears all parser state and empties every stage; the block then
// accepts a fresh sentence at once.
// When the receiver stalls, results queue in the two conversion stages and
// the finished-sentence register; characters keep flowing until a further
// final character finds all of them full, and only then is tready dropped.
module nmea_gga_sentence_parser_unit #(
  parameter int unsigned FracDigits = nggp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] ch
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic                         m_axis_tuser_o,  // [0] status
  // [0] valid_fix, [30:1] utc_stamp, [65:31] latitude, [100:66] longitude,
  // [116:101] fix_qual, [132:117] sats_used, [160:133] hdop,
  // [188:161] altitude, [216:189] geoid_sep, [244:217] diff_age,
  // [260:245] station_id, [263:261] zero
  output logic [nggp_pkg::TDATA_W-1:0] m_axis_tdata_o
);

  logic            snap_valid;
  logic            snap_ready;
  nggp_pkg::snap_t snap;

  nggp_parse #(
    .FracDigits(FracDigits)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .snap_valid_o   (snap_valid),
    .snap_ready_i   (snap_ready),
    .snap_o         (snap)
  );

  nggp_conv u_conv (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_valid_i   (snap_valid),
    .snap_ready_o   (snap_ready),
    .snap_i         (snap),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

endmodule

@@ rtl/core/nggp_parse.sv @@
module nggp_parse #(
  parameter int unsigned FracDigits = nggp_pkg::FRAC_DIGITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,
  input  logic            s_axis_tlast_i,
  output logic            snap_valid_o,
  input  logic            snap_ready_i,
  output nggp_pkg::snap_t snap_o
);

  localparam logic [2:0]  FRAC_K    = 3'(FracDigits);
  localparam logic [63:0] COORD_DIV = 64'd100 * nggp_pkg::pow10(3'(FracDigits));
  localparam logic [63:0] DEG_S     = 64'(nggp_pkg::ACC_MAX) / COORD_DIV;
  localparam logic [63:0] REM_S     = 64'(nggp_pkg::ACC_MAX) % COORD_DIV;

  typedef struct packed {
    logic [3:0]       fld;
    logic             first;
    logic             star;
    logic [1:0]       tag_st;
    logic             tag;
    logic [34:0]      acc;
    logic             neg;
    logic             pnt;
    logic             stop;
    logic             nemp;
    logic [2:0]       frac;
    logic [27:0]      dq;
    logic [29:0]      dr;
    logic [29:0]      utc;
    nggp_pkg::coord_t lat;
    nggp_pkg::coord_t lon;
    logic [15:0]      fix;
    logic [15:0]      sats;
    logic [27:0]      hdop;
    logic [27:0]      alt;
    logic [27:0]      geoid;
    logic [27:0]      age;
    logic [15:0]      station;
  } state_t;

  logic             in_v_q;
  logic [7:0]       ch_q;
  logic             last_q;
  logic             consume;
  state_t           st_q, st_d, st_clr, nm;
  logic             snap_v_q;
  nggp_pkg::snap_t  snap_q;

  logic [7:0]       c;
  logic [2:0]       k;
  logic             skip, proc, is_comma, is_star, do_feed, first_ch, is_digit;
  logic [3:0]       dig;
  logic [38:0]      acc10;
  logic [29:0]      dr_t;
  logic [9:0]       t10;
  logic [3:0]       kk;
  logic             commit_en;
  logic [2:0]       pad;
  logic [44:0]      scaled;
  logic [34:0]      mag;
  logic [29:0]      m_utc;
  logic [15:0]      m_i16;
  logic [27:0]      m_i28;
  logic             sat;
  nggp_pkg::coord_t cv;

  // Input register: take a request unless a finished sentence is still blocked
  assign consume         = in_v_q && (!last_q || !snap_v_q || snap_ready_i);
  assign s_axis_tready_o = !in_v_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      ch_q   <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  // Fraction digits kept for the current field
  always_comb begin
    case (st_q.fld)
      nggp_pkg::FLD_LAT, nggp_pkg::FLD_LON:   k = FRAC_K;
      nggp_pkg::FLD_TIME, nggp_pkg::FLD_HDOP, nggp_pkg::FLD_ALT,
      nggp_pkg::FLD_GEOID, nggp_pkg::FLD_AGE: k = 3'd3;
      default:                                k = 3'd0;
    endcase
  end

  // Digit arithmetic: accumulator, and running split by the degree divisor
  always_comb begin
    c        = ch_q;
    dig      = 4'(c - nggp_pkg::CH_ZERO);
    is_digit = (c >= nggp_pkg::CH_ZERO) && (c <= nggp_pkg::CH_NINE);
    acc10    = 39'(st_q.acc) * 39'd10 + 39'(dig);
    dr_t     = 30'(34'(st_q.dr) * 34'd10 + 34'(dig));
    t10      = 10'(st_q.dr[6:0]) * 10'd10 + 10'(dig);
    kk       = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (t10 >= 10'(j * 100)) kk = 4'(j);
    end
  end

  // Feed one character into the number being built
  always_comb begin
    skip     = st_q.first && (c == nggp_pkg::CH_DOLLAR);
    proc     = !skip && !st_q.star;
    is_comma = c == nggp_pkg::CH_COMMA;
    is_star  = c == nggp_pkg::CH_STAR;
    do_feed  = proc && !is_comma && !is_star;
    first_ch = !st_q.nemp;
    nm       = st_q;
    if (do_feed) begin
      nm.nemp = 1'b1;
      if (first_ch && st_q.fld == nggp_pkg::FLD_NS) begin
        nm.lat.hemi = (c == nggp_pkg::CH_S) || (c == nggp_pkg::CH_W);
      end
      if (first_ch && st_q.fld == nggp_pkg::FLD_EW) begin
        nm.lon.hemi = (c == nggp_pkg::CH_S) || (c == nggp_pkg::CH_W);
      end
      if (!st_q.stop) begin
        if (is_digit) begin
          if (!(st_q.pnt && st_q.frac >= k)) begin
            nm.acc = (acc10 > 39'(nggp_pkg::ACC_MAX)) ? nggp_pkg::ACC_MAX : acc10[34:0];
            if (st_q.pnt) begin
              nm.frac = st_q.frac + 3'd1;
              nm.dr   = dr_t;
            end else begin
              nm.dr = 30'(t10 - 10'(kk) * 10'd100);
              nm.dq = 28'(st_q.dq * 28'd10 + 28'(kk));
            end
          end
        end else if (c == nggp_pkg::CH_POINT && !st_q.pnt && k != 3'd0) begin
          nm.pnt = 1'b1;
        end else if (first_ch && (c == nggp_pkg::CH_MINUS || c == nggp_pkg::CH_PLUS)) begin
          nm.neg = c == nggp_pkg::CH_MINUS;
        end else begin
          nm.stop = 1'b1;
        end
      end
    end
  end

  // Scale, saturate and clip the number at the end of its field
  always_comb begin
    pad    = (k >= nm.frac) ? 3'(k - nm.frac) : 3'd0;
    scaled = 45'(nm.acc) * 45'(10'(nggp_pkg::pow10({1'b0, pad[1:0]})));
    mag    = (scaled > 45'(nggp_pkg::ACC_MAX)) ? nggp_pkg::ACC_MAX : scaled[34:0];
    m_utc  = nm.neg ? 30'd0 : ((mag > 35'd999999999) ? 30'd999999999 : mag[29:0]);
    if (nm.neg) begin
      m_i16 = (mag > 35'd32768) ? 16'h8000 : 16'(-mag[15:0]);
    end else begin
      m_i16 = (mag > 35'd32767) ? 16'h7FFF : mag[15:0];
    end
    m_i28  = (mag > 35'd99999999) ? 28'd99999999 : mag[27:0];
    if (nm.neg) m_i28 = 28'(-m_i28);
    sat     = (nm.acc >= nggp_pkg::ACC_MAX) || (nm.acc > nggp_pkg::acc_lim(pad));
    cv      = '0;
    cv.deg  = sat ? DEG_S[27:0] : nm.dq;
    cv.rem  = sat ? REM_S[29:0] : nm.dr;
    cv.frac = sat ? FRAC_K : nm.frac;
    cv.neg  = nm.neg && (nm.acc != 35'd0);
  end

  // Next state: tag search, field stepping, commit
  always_comb begin
    st_d        = nm;
    st_d.first  = 1'b0;
    st_d.tag    = st_q.tag || (st_q.tag_st == 2'd2 && c == nggp_pkg::CH_A);
    if (c == nggp_pkg::CH_G) begin
      st_d.tag_st = (st_q.tag_st != 2'd0) ? 2'd2 : 2'd1;
    end else begin
      st_d.tag_st = 2'd0;
    end
    st_d.star   = st_q.star || (proc && is_star);
    commit_en   = (proc && (is_comma || is_star)) || (last_q && !st_q.star);
    if (commit_en) begin
      case (st_q.fld)
        nggp_pkg::FLD_TIME:    st_d.utc     = m_utc;
        nggp_pkg::FLD_LAT:     st_d.lat     = '{deg: cv.deg, rem: cv.rem, frac: cv.frac,
                                                neg: cv.neg, hemi: nm.lat.hemi};
        nggp_pkg::FLD_LON:     st_d.lon     = '{deg: cv.deg, rem: cv.rem, frac: cv.frac,
                                                neg: cv.neg, hemi: nm.lon.hemi};
        nggp_pkg::FLD_FIX:     st_d.fix     = m_i16;
        nggp_pkg::FLD_SATS:    st_d.sats    = m_i16;
        nggp_pkg::FLD_HDOP:    st_d.hdop    = m_i28;
        nggp_pkg::FLD_ALT:     st_d.alt     = m_i28;
        nggp_pkg::FLD_GEOID:   st_d.geoid   = m_i28;
        nggp_pkg::FLD_AGE:     st_d.age     = m_i28;
        nggp_pkg::FLD_STATION: st_d.station = m_i16;
        default: ;
      endcase
      st_d.acc  = '0;
      st_d.neg  = 1'b0;
      st_d.pnt  = 1'b0;
      st_d.stop = 1'b0;
      st_d.nemp = 1'b0;
      st_d.frac = '0;
      st_d.dq   = '0;
      st_d.dr   = '0;
    end
    if (proc && is_comma && st_q.fld != nggp_pkg::FLD_LIMIT) begin
      st_d.fld = st_q.fld + 4'd1;
    end
    st_clr       = '0;
    st_clr.first = 1'b1;
  end

  // Hold parser state; drop it back to reset after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= st_clr;
    end else if (consume) begin
      st_q <= last_q ? st_clr : st_d;
    end
  end

  // Finished sentence register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
    end else begin
      snap_v_q <= (consume && last_q) || (snap_v_q && !snap_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && last_q) begin
      snap_q.status  <= !st_d.tag;
      snap_q.utc     <= st_d.utc;
      snap_q.lat     <= st_d.lat;
      snap_q.lon     <= st_d.lon;
      snap_q.fix     <= st_d.fix;
      snap_q.sats    <= st_d.sats;
      snap_q.hdop    <= st_d.hdop;
      snap_q.alt     <= st_d.alt;
      snap_q.geoid   <= st_d.geoid;
      snap_q.age     <= st_d.age;
      snap_q.station <= st_d.station;
    end
  end

  assign snap_valid_o = snap_v_q;
  assign snap_o       = snap_q;

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && last_q |=> st_q.fld == 4'd0 && st_q.first && !st_q.star)
    else $error("parser state not cleared after final character");

  a_field_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && !last_q |=> st_q.fld >= $past(st_q.fld))
    else $error("field number went backwards inside a sentence");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_v_q && last_q && snap_v_q)
    else $error("input stalled without a blocked final character");

endmodule

@@ rtl/core/nggp_conv.sv @@
module nggp_conv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         snap_valid_i,
  output logic                         snap_ready_o,
  input  nggp_pkg::snap_t              snap_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic                         m_axis_tuser_o,
  output logic [nggp_pkg::TDATA_W-1:0] m_axis_tdata_o
);

  // Reciprocal of 60 scaled by 2^36, exact for operands below 1.5e9
  localparam logic [30:0] RECIP60 = 31'd1145324613;
  localparam logic [34:0] DEG_MAX = 35'd10000000000;

  typedef struct packed {
    logic [29:0] x;
    logic [50:0] dp;
    logic        neg;
  } cpart_t;

  typedef struct packed {
    logic        status;
    logic [29:0] utc;
    cpart_t      lat;
    cpart_t      lon;
    logic [15:0] fix;
    logic [15:0] sats;
    logic [27:0] hdop;
    logic [27:0] alt;
    logic [27:0] geoid;
    logic [27:0] age;
    logic [15:0] station;
  } mid_t;

  logic                         a_v_q, o_v_q;
  mid_t                         a_q, a_d;
  logic [nggp_pkg::TDATA_W-1:0] o_q, o_d;
  logic                         o_u_q;
  logic                         o_adv, a_adv;
  logic [34:0]                  lat_deg, lon_deg;

  function automatic cpart_t split(input nggp_pkg::coord_t cd);
    cpart_t r;
    logic [55:0] xm;
    xm    = 56'(cd.rem) * 56'(24'(nggp_pkg::pow10(3'(3'd7 - cd.frac)))) + 56'd30;
    r.x   = xm[29:0];
    r.dp  = 51'(cd.deg) * 51'd10000000;
    r.neg = cd.neg ^ cd.hemi;
    return r;
  endfunction

  function automatic logic [34:0] degrees(input cpart_t p);
    logic [60:0] qm;
    logic [51:0] mag;
    logic [34:0] m35;
    qm  = 61'(p.x) * 61'(RECIP60);
    mag = 52'(p.dp) + 52'(qm[59:36]);
    m35 = (mag > 52'(DEG_MAX)) ? DEG_MAX : mag[34:0];
    return p.neg ? 35'(-m35) : m35;
  endfunction

  assign o_adv        = !o_v_q || m_axis_tready_i;
  assign a_adv        = !a_v_q || o_adv;
  assign snap_ready_o = a_adv;

  // First stage: minute remainder scaled, whole degrees times 1e7
  always_comb begin
    a_d.status  = snap_i.status;
    a_d.utc     = snap_i.utc;
    a_d.lat     = split(snap_i.lat);
    a_d.lon     = split(snap_i.lon);
    a_d.fix     = snap_i.fix;
    a_d.sats    = snap_i.sats;
    a_d.hdop    = snap_i.hdop;
    a_d.alt     = snap_i.alt;
    a_d.geoid   = snap_i.geoid;
    a_d.age     = snap_i.age;
    a_d.station = snap_i.station;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_adv) begin
      a_v_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && snap_valid_i) a_q <= a_d;
  end

  // Second stage: divide minutes by 60, add, clip and pack the result (all zero when status is set)
  always_comb begin
    lat_deg = degrees(a_q.lat);
    lon_deg = degrees(a_q.lon);
    o_d     = '0;
    if (!a_q.status) begin
      o_d[0]       = !a_q.fix[15] && (a_q.fix != 16'd0);
      o_d[30:1]    = a_q.utc;
      o_d[65:31]   = lat_deg;
      o_d[100:66]  = lon_deg;
      o_d[116:101] = a_q.fix;
      o_d[132:117] = a_q.sats;
      o_d[160:133] = a_q.hdop;
      o_d[188:161] = a_q.alt;
      o_d[216:189] = a_q.geoid;
      o_d[244:217] = a_q.age;
      o_d[260:245] = a_q.station;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_adv) begin
      o_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_adv && a_v_q) begin
      o_q   <= o_d;
      o_u_q <= a_q.status;
    end
  end

  assign m_axis_tvalid_o = o_v_q;
  assign m_axis_tuser_o  = o_u_q;
  assign m_axis_tdata_o  = o_q;

endmodule
